### design/circular_double_ended_queue_core_macros.svh
// Assertion macros for the deque core.
// Depends on a clock named clock and a reset named reset in the including scope.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque core check failed");

// Next-cycle implication, checked outside reset.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque core check failed");

`endif

### design/cdq_pkg.sv
// Package for the circular deque core: request/response types, opcodes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CAP_WIDTH     = 5;
   localparam int CAP_RESET     = 16;
   localparam int WORD_WIDTH    = 32;
   localparam int OP_WIDTH      = 3;

   localparam logic [OP_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_QUERY      = 3'd4;

   localparam logic signed [WORD_WIDTH-1:0] EMPTY_WORD = '1;

   typedef struct packed {
      logic [OP_WIDTH-1:0]          opcode;
      logic signed [WORD_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic                         ok;
      logic signed [WORD_WIDTH-1:0] popped_value;
      logic signed [WORD_WIDTH-1:0] front_value;
      logic signed [WORD_WIDTH-1:0] rear_value;
      logic                         is_empty;
      logic                         is_full;
   } rsp_type;

endpackage

`default_nettype wire

### design/circular_double_ended_queue_core.sv
// Circular double-ended queue core: entry memory, head/tail pointers, cached end words.
// Depends on cdq_pkg and circular_double_ended_queue_core_macros.svh.
//
//   channel | ports                      | handshake
//   --------+----------------------------+-------------------------------------
//   request | start, busy, req_data      | taken when start high, busy and csr_we low
//   result  | rsp_valid, rsp_data        | one cycle, cannot be held off
//   csr     | csr_we, csr_wdata          | capacity written when csr_we is high
//
// At the accept edge a request updates pointers, writes a pushed word and reads the new
// end entry from the registered-read memory; the result shows in the next cycle with
// busy high, and no new request is taken while busy is high.
// The receiver cannot stall; busy is high only for the one result cycle.
// Synchronous reset empties the deque and sets capacity to 16 (limited to DEPTH).
// A capacity write empties the deque; the memory contents are kept.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_double_ended_queue_core_macros.svh"

module circular_double_ended_queue_core #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire cdq_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   output cdq_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_we,
   input  wire [cdq_pkg::CAP_WIDTH-1:0]         csr_wdata
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (CW > cdq_pkg::CAP_WIDTH) ? CW : cdq_pkg::CAP_WIDTH;
   localparam int CAP_INIT = (cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET;

   logic signed [cdq_pkg::WORD_WIDTH-1:0] mem [DEPTH];

   logic [IW-1:0]                         head_ff, head_in;
   logic [IW-1:0]                         tail_ff, tail_in;
   logic [CW-1:0]                         cnt_ff, cnt_in;
   logic [CW-1:0]                         cap_ff;
   logic signed [cdq_pkg::WORD_WIDTH-1:0] front_ff, front_in;
   logic signed [cdq_pkg::WORD_WIDTH-1:0] rear_ff, rear_in;
   logic signed [cdq_pkg::WORD_WIDTH-1:0] pop_ff, pop_in;
   logic signed [cdq_pkg::WORD_WIDTH-1:0] rd_data_ff;
   logic                                  ok_ff, ok_in;
   logic                                  fixf_ff, fixf_in;
   logic                                  fixr_ff, fixr_in;
   logic                                  pend_ff;

   logic                                  accept;
   logic                                  mem_we;
   logic [IW-1:0]                         waddr;
   logic [IW-1:0]                         raddr;
   logic [AW-1:0]                         cap_wide;
   logic [CW-1:0]                         cap_sat;
   logic signed [cdq_pkg::WORD_WIDTH-1:0] front_out;
   logic signed [cdq_pkg::WORD_WIDTH-1:0] rear_out;

   assign accept = start && !pend_ff;
   assign busy   = pend_ff;

   // Clamp a written capacity into 1..DEPTH.
   always_comb begin
      cap_wide = AW'(csr_wdata);
      if (cap_wide == '0) begin
         cap_sat = CW'(1);
      end else if (cap_wide > AW'(DEPTH)) begin
         cap_sat = CW'(DEPTH);
      end else begin
         cap_sat = CW'(cap_wide);
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      cnt_in   = cnt_ff;
      front_in = front_ff;
      rear_in  = rear_ff;
      pop_in   = cdq_pkg::EMPTY_WORD;
      ok_in    = 1'b0;
      fixf_in  = 1'b0;
      fixr_in  = 1'b0;
      mem_we   = 1'b0;
      waddr    = head_ff;
      raddr    = head_ff;
      case (req_data.opcode)
         cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
            if (cnt_ff < cap_ff) begin
               ok_in  = 1'b1;
               mem_we = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == '0) begin
                  head_in  = '0;
                  tail_in  = '0;
                  waddr    = '0;
                  front_in = req_data.value;
                  rear_in  = req_data.value;
               end else if (req_data.opcode == cdq_pkg::OP_PUSH_FRONT) begin
                  head_in  = (head_ff == '0) ? IW'(cap_ff - CW'(1)) : head_ff - IW'(1);
                  waddr    = head_in;
                  front_in = req_data.value;
               end else begin
                  tail_in = ((CW'(tail_ff) + CW'(1)) >= cap_ff) ? '0 : tail_ff + IW'(1);
                  waddr   = tail_in;
                  rear_in = req_data.value;
               end
            end
         end
         cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
            if (cnt_ff != '0) begin
               ok_in  = 1'b1;
               cnt_in = cnt_ff - CW'(1);
               if (req_data.opcode == cdq_pkg::OP_POP_FRONT) begin
                  pop_in  = front_ff;
                  head_in = ((CW'(head_ff) + CW'(1)) >= cap_ff) ? '0 : head_ff + IW'(1);
                  raddr   = head_in;
                  fixf_in = 1'b1;
               end else begin
                  pop_in  = rear_ff;
                  tail_in = (tail_ff == '0) ? IW'(cap_ff - CW'(1)) : tail_ff - IW'(1);
                  raddr   = tail_in;
                  fixr_in = 1'b1;
               end
               // Drop to the empty layout when the last element leaves.
               if (cnt_in == '0) begin
                  head_in  = '0;
                  tail_in  = '0;
                  front_in = cdq_pkg::EMPTY_WORD;
                  rear_in  = cdq_pkg::EMPTY_WORD;
                  fixf_in  = 1'b0;
                  fixr_in  = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         mem[waddr] <= req_data.value;
      end
      rd_data_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         cnt_ff   <= '0;
         cap_ff   <= CW'(CAP_INIT);
         front_ff <= cdq_pkg::EMPTY_WORD;
         rear_ff  <= cdq_pkg::EMPTY_WORD;
         pend_ff  <= 1'b0;
         fixf_ff  <= 1'b0;
         fixr_ff  <= 1'b0;
      end else if (csr_we) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         cnt_ff   <= '0;
         cap_ff   <= cap_sat;
         front_ff <= cdq_pkg::EMPTY_WORD;
         rear_ff  <= cdq_pkg::EMPTY_WORD;
         pend_ff  <= 1'b0;
         fixf_ff  <= 1'b0;
         fixr_ff  <= 1'b0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
         pend_ff  <= 1'b1;
         fixf_ff  <= fixf_in;
         fixr_ff  <= fixr_in;
      end else if (pend_ff) begin
         // Fold the freshly read end word into the cache.
         front_ff <= front_out;
         rear_ff  <= rear_out;
         pend_ff  <= 1'b0;
         fixf_ff  <= 1'b0;
         fixr_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff  <= ok_in;
         pop_ff <= pop_in;
      end
   end

   assign front_out = fixf_ff ? rd_data_ff : front_ff;
   assign rear_out  = fixr_ff ? rd_data_ff : rear_ff;

   assign rsp_valid             = pend_ff;
   assign rsp_data.ok           = ok_ff;
   assign rsp_data.popped_value = pop_ff;
   assign rsp_data.front_value  = front_out;
   assign rsp_data.rear_value   = rear_out;
   assign rsp_data.is_empty     = (cnt_ff == '0);
   assign rsp_data.is_full      = (cnt_ff == cap_ff);

   `CDQ_ASSERT_NEXT(a_accept_gives_result, start && !busy && !csr_we, rsp_valid)
   `CDQ_ASSERT_NEXT(a_single_result, rsp_valid, !rsp_valid)
   `CDQ_ASSERT_NOW(a_count_in_capacity, 1'b1, cnt_ff <= cap_ff)
   `CDQ_ASSERT_NOW(a_empty_layout, cnt_ff == '0, head_ff == '0 && tail_ff == '0 && !fixf_ff && !fixr_ff)

endmodule

`default_nettype wire
